### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the domino tiling counter checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dtc_pkg.sv
// ----------------------------------------------------------------------------
// Domino tiling counter package
// Field widths and the controller state type shared by the block's files.
// ----------------------------------------------------------------------------
`default_nettype none

package dtc_pkg;

  // Width of a grid side on the input channel
  localparam int SIDE_W = 4;

  // Width of one stored tiling count and of the delivered result
  localparam int COUNT_W     = 64;
  localparam int COUNT_OUT_W = 63;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_DRAIN,
    ST_FINISH
  } dtc_state_t;

endpackage

`default_nettype wire

### hdl/dtc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/dtc_fit.sv
// ----------------------------------------------------------------------------
// Profile transition check
// Tells whether a row with incoming profile from_mask can be completed so
// that it leaves profile to_mask: no cell covered twice, and every horizontal
// gap (bounded by covered cells or the grid edge) of even length.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_fit #(
  parameter int MAX_SIDE = 11
) (
  input  logic [MAX_SIDE-1:0]        from_mask,
  input  logic [MAX_SIDE-1:0]        to_mask,
  input  logic [dtc_pkg::SIDE_W-1:0] width,
  output logic                       fit
);

  import dtc_pkg::*;

  // Walk the columns with a one-bit run parity
  always_comb begin
    logic [MAX_SIDE-1:0] filled;
    logic                odd;
    logic                ok;
    logic                blocked;
    filled  = from_mask | to_mask;
    odd     = 1'b0;
    ok      = ((from_mask & to_mask) == '0);
    blocked = 1'b0;
    for (int col = 0; col < MAX_SIDE; col++) begin
      blocked = (SIDE_W'(col) >= width) || filled[col];
      if (blocked) begin
        if (odd) begin
          ok = 1'b0;
        end
        odd = 1'b0;
      end else begin
        odd = ~odd;
      end
    end
    if (odd) begin
      ok = 1'b0;
    end
    fit = ok;
  end

endmodule

`default_nettype wire

### hdl/domino_tiling_counter.sv
// ----------------------------------------------------------------------------
// Domino tiling counter
// Counts the tilings of an h x w grid by 1x2 dominoes with a row profile DP.
// ----------------------------------------------------------------------------
// Each transaction on the input gives two grid sides; sides above MAX_SIDE
// are clamped to MAX_SIDE, the narrower side becomes the profile width w and
// the other the row count h. One item is worked at a time. A grid with both
// sides odd, or with no cells, is answered from the input alone. Otherwise,
// for each row and each target profile the block reads every source profile
// count from the count memory, one read per cycle through its single read
// port, and then passes through a drain state to let the last write of the
// row land before the next row reads it. The count memory needs no clearing:
// row 0 counts are implied, and each later row reads only entries the row
// before has written. A result waits in the output register while the next
// item is already accepted; a finished item stalls until that register is
// free.
`default_nettype none

module domino_tiling_counter #(
  parameter int MAX_SIDE = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dtc_pkg::SIDE_W-1:0]      grid_height,
  input  logic [dtc_pkg::SIDE_W-1:0]      grid_width,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dtc_pkg::COUNT_OUT_W-1:0] tiling_count
);

  import dtc_pkg::*;

  localparam int PROF_W = MAX_SIDE;
  localparam int DEPTH  = 2 << MAX_SIDE;

  dtc_state_t state, state_next;

  // Item geometry
  logic [SIDE_W-1:0] h_clamp, w_clamp, w_min, h_max;
  logic              trivial_zero, trivial_one;
  logic [SIDE_W-1:0] width, rows, row_idx;
  logic [PROF_W-1:0] mask;

  // Issue counters
  logic [PROF_W-1:0] a_idx, b_idx;
  logic              bank;
  logic              a_last, b_last, row_last;

  // Controls
  logic in_accept, issue, load_out;
  logic fit;

  // Read stage
  logic              p_valid;
  logic              p_fit, p_last, p_first, p_a0, p_final, p_wbank;
  logic [PROF_W-1:0] p_b;

  // Accumulate stage
  logic [COUNT_W-1:0]     rd_data, term, addend, sum, acc;
  logic [COUNT_OUT_W-1:0] res;
  logic                   we;

  // Clamp and order the sides
  always_comb begin
    h_clamp = (grid_height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_height;
    w_clamp = (grid_width > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_width;
    w_min   = (w_clamp > h_clamp) ? h_clamp : w_clamp;
    h_max   = (w_clamp > h_clamp) ? w_clamp : h_clamp;
    trivial_zero = w_min[0] & h_max[0];
    trivial_one  = (w_min == '0);
  end

  assign a_last   = (a_idx == mask);
  assign b_last   = (b_idx == mask);
  assign row_last = (row_idx == (rows - SIDE_W'(1)));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (trivial_zero || trivial_one) ? ST_FINISH : ST_ROW;
        end
      end
      ST_ROW: begin
        if (a_last && b_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = row_last ? ST_FINISH : ST_ROW;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_ROW:    issue    = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: load_out = !out_valid || out_ready;
      default:   ;
    endcase
  end

  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch geometry and step the issue counters
  always_ff @(posedge clk) begin
    if (in_accept) begin
      width   <= w_min;
      rows    <= h_max;
      mask    <= ~({PROF_W{1'b1}} << w_min);
      row_idx <= '0;
      a_idx   <= '0;
      b_idx   <= '0;
      bank    <= 1'b0;
    end else if (issue) begin
      if (a_last) begin
        a_idx <= '0;
        b_idx <= b_last ? '0 : b_idx + PROF_W'(1);
      end else begin
        a_idx <= a_idx + PROF_W'(1);
      end
    end else if (state == ST_DRAIN && !row_last) begin
      row_idx <= row_idx + SIDE_W'(1);
      bank    <= ~bank;
    end
  end

  dtc_fit #(
    .MAX_SIDE (MAX_SIDE)
  ) u_fit (
    .from_mask (a_idx),
    .to_mask   (b_idx),
    .width     (width),
    .fit       (fit)
  );

  dtc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (we),
    .waddr ({p_wbank, p_b}),
    .wdata (sum),
    .re    (issue),
    .raddr ({bank, a_idx}),
    .rdata (rd_data)
  );

  // Carry the transition flags alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    p_fit   <= fit;
    p_last  <= a_last;
    p_b     <= b_idx;
    p_first <= (row_idx == '0);
    p_a0    <= (a_idx == '0);
    p_final <= row_last;
    p_wbank <= ~bank;
  end

  // Accumulate source counts; row 0 holds a single count at profile zero
  always_comb begin
    term   = p_first ? COUNT_W'(p_a0) : rd_data;
    addend = p_fit ? term : '0;
    sum    = acc + addend;
    we     = p_valid && p_last;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      acc <= '0;
      res <= COUNT_OUT_W'(trivial_one);
    end else if (p_valid) begin
      acc <= p_last ? '0 : sum;
      if (p_last && p_final && (p_b == '0)) begin
        res <= sum[COUNT_OUT_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      tiling_count <= res;
    end
  end

endmodule

`default_nettype wire

### hdl/dtc_checker.sv
// ----------------------------------------------------------------------------
// Domino tiling counter port checker
// Watches the top-level ports over time and flags handshake and flow slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dtc_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [dtc_pkg::COUNT_OUT_W-1:0] tiling_count
);

  import dtc_pkg::*;

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(tiling_count), "stalled result changed")

  // Take one item at a time
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input ready right after a transaction")

  // Stay ready while idle
  `ASSERT_NEXT(a_idle_holds, clk, rst, in_ready && !in_valid, in_ready, "ready dropped with no transaction")

  // A new result appears only as an item finishes
  `ASSERT_IMPLY(a_result_from_work, clk, rst, $rose(out_valid), $past(!in_ready), "result appeared with no item in work")

  // Come out of reset idle and empty
  `ASSERT_NEXT(a_reset_state, clk, 1'b0, rst, !out_valid && in_ready, "block not idle after reset")

endmodule

bind domino_tiling_counter dtc_checker u_dtc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .tiling_count (tiling_count)
);

`default_nettype wire
